### sv/cscan_pkg.sv
// C-SCAN disk scheduler: shared widths, codes, state and segment types.
// No dependencies; every other file but cscan_ram uses this package.
package cscan_pkg;

	localparam int CYL_W     = 16;	// cylinder field and request store width
	localparam int CYL_BITS  = 16;	// disk size cap is 2**CYL_BITS cylinders
	localparam int POS_W     = 17;	// head position and distance width
	localparam int SUM_W     = 18;	// accumulated movement
	localparam int DISK_W    = 17;	// disk_cylinders register
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

	localparam logic [DISK_W-1:0] DISK_CYL_RESET = 17'h10000;
	localparam logic [SUM_W-1:0]  MOVE_MAX       = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLMP_RD,
		ST_CLMP_WR,
		ST_SORT_BEGIN,
		ST_SORT_LOAD,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_SRCH_BEGIN,
		ST_SRCH_CMP,
		ST_EM_NEXT,
		ST_EM_DIST,
		ST_EM_OUT
	} state_t;

	// service order: first request run, two disk ends, second request run
	typedef enum logic [1:0] {
		SEG_FIRST,
		SEG_END_A,
		SEG_END_B,
		SEG_SECOND
	} seg_t;

	typedef struct packed {
		logic             gt;	// a > b
		logic [POS_W-1:0] diff;	// |a - b|
	} dist_res_t;

endpackage

### sv/cscan_if.sv
// Handshake channels of the C-SCAN disk scheduler: command items in, stop items out.
// Depends on cscan_pkg for field widths.
interface cscan_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [cscan_pkg::ACT_W-1:0]   action;
	logic [cscan_pkg::CYL_W-1:0]   cylinder;

	modport source (output valid, output action, output cylinder, input ready);
	modport sink   (input valid, input action, input cylinder, output ready);
endinterface

interface cscan_stop_if;
	logic                          valid;
	logic                          ready;
	logic [cscan_pkg::CYL_W-1:0]   served_cylinder;
	logic                          is_disk_end;
	logic [cscan_pkg::SUM_W-1:0]   total_movement;
	logic                          last_of_run;

	modport source (output valid, output served_cylinder, output is_disk_end,
		output total_movement, output last_of_run, input ready);
	modport sink   (input valid, input served_cylinder, input is_disk_end,
		input total_movement, input last_of_run, output ready);
endinterface

### sv/cscan_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cscan_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/cscan_dist_unit.sv
// Shared compare / absolute-difference unit used by every phase of the sequencer.
// Depends on cscan_pkg.
module cscan_dist_unit (
	input  logic [cscan_pkg::POS_W-1:0] a,
	input  logic [cscan_pkg::POS_W-1:0] b,
	output cscan_pkg::dist_res_t        res
);
	import cscan_pkg::*;

	logic [POS_W-1:0] a_minus_b;
	logic [POS_W-1:0] b_minus_a;

	assign a_minus_b = a - b;
	assign b_minus_a = b - a;
	assign res.gt    = a > b;
	assign res.diff  = res.gt ? a_minus_b : b_minus_a;

endmodule

### sv/cscan_disk_scheduler.sv
// C-SCAN disk scheduler. Load and clear items are accepted whenever the block is idle.
// A start item keeps ready low through a clamp pass, an insertion sort (skipped when n < 2),
// a head search, and then the stops (n requests plus the two disk ends, n + 2 stops),
// each of which can be held while the output stalls.
// Reset clears control state and loads register defaults; store contents are
// undefined until written and are never read beyond the request count.
module cscan_disk_scheduler #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cscan_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cscan_pkg::DISK_W-1:0]      cfg_data,
	cscan_cmd_if.sink                         cmd,
	cscan_stop_if.source                      stop
);
	import cscan_pkg::*;

	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int AW    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CAP_W = (CYL_BITS + 1 > DISK_W) ? CYL_BITS + 1 : DISK_W;
	localparam logic [CAP_W-1:0] CYL_CAP = CAP_W'(1) << CYL_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

	state_t state_q, state_d;
	seg_t   seg_q;

	logic [CYL_W-1:0]  head_start_q;
	logic [DISK_W-1:0] disk_cyl_q;
	logic              sweep_up_q;

	logic [CNT_W-1:0] count_q, i_q, j_q, p_q, start_q;
	logic [CNT_W-1:0] i_inc, i_dec, j_dec2, p_dec, p_step, bound;
	logic [POS_W-1:0] head_q, last_q, last_now, cyl_q, end_cyl;
	logic [POS_W-1:0] dist_q;
	logic [SUM_W-1:0] sum_q, sum_sat;
	logic [SUM_W:0]   sum_wide;
	logic [CYL_W-1:0] v_q;

	logic [CAP_W-1:0] disk_ext, disk_nz, disk_cl;

	logic             out_valid_q, out_end_q, out_last_q;
	logic [CYL_W-1:0] out_cyl_q;
	logic [SUM_W-1:0] out_sum_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [CYL_W-1:0] ram_wdata, ram_rdata;

	logic [POS_W-1:0] ua, ub;
	dist_res_t        ures;

	logic cmd_fire, out_free, out_load, seg_is_end, run_done, em_last;

	function automatic logic [CNT_W-1:0] i_mux_up(input logic [CNT_W-1:0] x);
		i_mux_up = x + CNT_W'(1);
	endfunction

	cscan_ram #(
		.WIDTH (CYL_W),
		.DEPTH (MAX_REQUESTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cscan_dist_unit u_unit (
		.a   (ua),
		.b   (ub),
		.res (ures)
	);

	// last cylinder from the disk size register, with zero and cap handling
	assign disk_ext = CAP_W'(disk_cyl_q);
	assign disk_nz  = (disk_ext == '0) ? CAP_W'(1) : disk_ext;
	assign disk_cl  = (disk_nz > CYL_CAP) ? CYL_CAP : disk_nz;
	assign last_now = POS_W'(disk_cl - CAP_W'(1));

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || stop.ready;
	assign out_load  = (state_q == ST_EM_OUT) && out_free;

	assign i_inc  = i_q + CNT_W'(1);
	assign i_dec  = i_q - CNT_W'(1);
	assign j_dec2 = j_q - CNT_W'(2);
	assign p_dec  = p_q - CNT_W'(1);
	assign p_step = sweep_up_q ? i_mux_up(p_q) : p_dec;

	assign bound      = (seg_q == SEG_SECOND) ? start_q : (sweep_up_q ? count_q : '0);
	assign seg_is_end = (seg_q == SEG_END_A) || (seg_q == SEG_END_B);
	assign end_cyl    = ((seg_q == SEG_END_A) == sweep_up_q) ? last_q : '0;
	assign run_done   = (i_inc == count_q);

	// last stop: end B with an empty second run, or the final entry of the second run
	assign em_last = ((seg_q == SEG_END_B) && (start_q == (sweep_up_q ? '0 : count_q)))
		|| ((seg_q == SEG_SECOND) && (p_step == start_q));

	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(dist_q);
	assign sum_sat  = sum_wide[SUM_W] ? MOVE_MAX : sum_wide[SUM_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.action == ACT_START)) begin
					state_d = (count_q == '0) ? ST_SORT_BEGIN : ST_CLMP_RD;
				end
			end
			ST_CLMP_RD: state_d = ST_CLMP_WR;
			ST_CLMP_WR: state_d = run_done ? ST_SORT_BEGIN : ST_CLMP_RD;
			ST_SORT_BEGIN: begin
				state_d = ((count_q == '0) || (count_q == CNT_W'(1))) ?
					ST_SRCH_BEGIN : ST_SORT_LOAD;
			end
			ST_SORT_LOAD: state_d = ST_SORT_CMP;
			ST_SORT_CMP: begin
				if (ures.gt) begin
					state_d = (j_q == CNT_W'(1)) ? ST_SORT_PUT : ST_SORT_CMP;
				end else begin
					state_d = run_done ? ST_SRCH_BEGIN : ST_SORT_LOAD;
				end
			end
			ST_SORT_PUT: state_d = run_done ? ST_SRCH_BEGIN : ST_SORT_LOAD;
			ST_SRCH_BEGIN: state_d = (count_q == '0) ? ST_EM_NEXT : ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				if (ures.gt || run_done) begin
					state_d = ST_EM_NEXT;
				end
			end
			ST_EM_NEXT: begin
				if (!seg_is_end && (p_q == bound)) begin
					state_d = (seg_q == SEG_SECOND) ? ST_IDLE : ST_EM_NEXT;
				end else begin
					state_d = ST_EM_DIST;
				end
			end
			ST_EM_DIST: state_d = ST_EM_OUT;
			ST_EM_OUT: begin
				if (out_free) begin
					state_d = em_last ? ST_IDLE : ST_EM_NEXT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM ports and shared unit operands
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = i_q[AW-1:0];
		ua        = POS_W'(ram_rdata);
		ub        = last_q;
		unique case (state_q)
			ST_IDLE: begin
				ua        = (cmd.action == ACT_LOAD) ? POS_W'(cmd.cylinder) : POS_W'(head_start_q);
				ub        = last_now;
				ram_we    = cmd_fire && (cmd.action == ACT_LOAD) && (count_q != CNT_MAX);
				ram_waddr = count_q[AW-1:0];
				ram_wdata = ures.gt ? last_now[CYL_W-1:0] : cmd.cylinder;
			end
			ST_CLMP_RD: ram_raddr = i_q[AW-1:0];
			ST_CLMP_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ures.gt ? last_q[CYL_W-1:0] : ram_rdata;
			end
			ST_SORT_BEGIN: ram_raddr = AW'(1);
			ST_SORT_LOAD: ram_raddr = i_dec[AW-1:0];
			ST_SORT_CMP: begin
				ub        = POS_W'(v_q);
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				if (ures.gt) begin
					ram_wdata = ram_rdata;
					ram_raddr = j_dec2[AW-1:0];
				end else begin
					ram_wdata = v_q;
					ram_raddr = i_inc[AW-1:0];
				end
			end
			ST_SORT_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = v_q;
				ram_raddr = i_inc[AW-1:0];
			end
			ST_SRCH_BEGIN: ram_raddr = '0;
			ST_SRCH_CMP: begin
				ub        = head_q;
				ram_raddr = i_inc[AW-1:0];
			end
			ST_EM_NEXT: ram_raddr = sweep_up_q ? p_q[AW-1:0] : p_dec[AW-1:0];
			ST_EM_DIST: begin
				ua = seg_is_end ? end_cyl : POS_W'(ram_rdata);
				ub = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seg_q        <= SEG_FIRST;
			head_start_q <= '0;
			disk_cyl_q   <= DISK_CYL_RESET;
			sweep_up_q   <= 1'b1;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			p_q          <= '0;
			start_q      <= '0;
			head_q       <= '0;
			last_q       <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_HEAD_START:     head_start_q <= cfg_data[CYL_W-1:0];
					CFG_DISK_CYLINDERS: disk_cyl_q   <= cfg_data;
					CFG_SWEEP_UP:       sweep_up_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (stop.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.action)
							ACT_LOAD: begin
								if (count_q != CNT_MAX) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_START: begin
								last_q <= last_now;
								head_q <= ures.gt ? last_now : POS_W'(head_start_q);
								sum_q  <= '0;
								i_q    <= '0;
							end
							ACT_CLEAR: count_q <= '0;
							default: begin
							end
						endcase
					end
				end
				ST_CLMP_WR:    i_q <= i_inc;
				ST_SORT_BEGIN: i_q <= CNT_W'(1);
				ST_SORT_LOAD:  j_q <= i_q;
				ST_SORT_CMP: begin
					if (ures.gt) begin
						j_q <= j_q - CNT_W'(1);
					end else begin
						i_q <= i_inc;
					end
				end
				ST_SORT_PUT: i_q <= i_inc;
				ST_SRCH_BEGIN: begin
					i_q     <= '0;
					start_q <= '0;
					p_q     <= '0;
					seg_q   <= SEG_FIRST;
				end
				ST_SRCH_CMP: begin
					if (ures.gt) begin
						start_q <= i_q;
						p_q     <= i_q;
					end else begin
						i_q <= i_inc;
						if (run_done) begin
							start_q <= count_q;
							p_q     <= count_q;
						end
					end
				end
				ST_EM_NEXT: begin
					if ((seg_q == SEG_FIRST) && (p_q == bound)) begin
						seg_q <= SEG_END_A;
					end
				end
				ST_EM_OUT: begin
					if (out_free) begin
						head_q <= cyl_q;
						sum_q  <= sum_sat;
						case (seg_q) inside
							SEG_FIRST, SEG_SECOND: p_q <= p_step;
							SEG_END_A: seg_q <= SEG_END_B;
							SEG_END_B: begin
								seg_q <= SEG_SECOND;
								p_q   <= sweep_up_q ? '0 : count_q;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_LOAD) begin
			v_q <= ram_rdata;
		end
		if (state_q == ST_EM_DIST) begin
			cyl_q  <= ua;
			dist_q <= ures.diff;
		end
		if (out_load) begin
			out_cyl_q  <= cyl_q[CYL_W-1:0];
			out_end_q  <= seg_is_end;
			out_sum_q  <= sum_sat;
			out_last_q <= em_last;
		end
	end

	assign stop.valid           = out_valid_q;
	assign stop.served_cylinder = out_cyl_q;
	assign stop.is_disk_end     = out_end_q;
	assign stop.total_movement  = out_sum_q;
	assign stop.last_of_run     = out_last_q;

endmodule

### bench/tb_cscan_disk_scheduler.sv
// Testbench for cscan_disk_scheduler: a directed table, then random load/start/clear runs.
// Each stop item is checked against a C-SCAN service order predictor kept in this file.
// Depends on cscan_pkg, cscan_cmd_if, cscan_stop_if and cscan_disk_scheduler from the RTL.
module tb_cscan_disk_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import cscan_pkg::*;

	localparam int NREQ         = 32;
	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE       = 16;
	localparam int DRAIN        = 40;
	localparam int HOLD_OFF     = 400;
	localparam int WATCHDOG     = 5000;
	localparam int PHASE_ITEMS  = 50;
	localparam int N_ROWS       = 32;

	localparam logic [ACT_W-1:0]     ACT_NOP   = 2'd3;	// undefined action, ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;	// no register behind it

	typedef struct packed {
		logic [CYL_W-1:0] served_cylinder;
		logic             is_disk_end;
		logic [SUM_W-1:0] total_movement;
		logic             last_of_run;
	} stop_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_SEND,
		ROW_SEND_TYPED,	// stops come from the ROW_STOP lines right above
		ROW_STOP
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        code;
		logic [DISK_W-1:0] value;
		stop_t             stop;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DISK_W-1:0]    cfg_data;

	cscan_cmd_if  cmd();
	cscan_stop_if stop();

	cscan_disk_scheduler #(
		.MAX_REQUESTS(NREQ)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stop     (stop)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predictor state and register copies
	logic [CYL_W-1:0]  req_store [NREQ];
	int unsigned       req_count;
	logic [CYL_W-1:0]  mirror_head;
	logic [DISK_W-1:0] mirror_disk;
	logic              mirror_up;
	logic [POS_W-1:0]  head_pos;
	logic [SUM_W-1:0]  move_sum;

	stop_t pending_stops [$];
	stop_t fresh_stops [$];

	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned send_gap_pct = 29;
	int unsigned recv_gap_pct = 55;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet = 0;

	// reset values: head 0, full 65536-cylinder disk, upward sweep
	row_t directed_rows [N_ROWS] = '{
		'{ROW_STOP, 2'd0, 17'd0, '{16'd65535, 1'b1, 18'd65535, 1'b0}},
		'{ROW_STOP, 2'd0, 17'd0, '{16'd0, 1'b1, 18'd131070, 1'b1}},
		'{ROW_SEND_TYPED, ACT_START, 17'd0, '0},
		'{ROW_SEND, ACT_LOAD, 17'd65535, '0},
		'{ROW_SEND, ACT_LOAD, 17'd0, '0},
		'{ROW_STOP, 2'd0, 17'd0, '{16'd65535, 1'b0, 18'd65535, 1'b0}},
		'{ROW_STOP, 2'd0, 17'd0, '{16'd65535, 1'b1, 18'd65535, 1'b0}},
		'{ROW_STOP, 2'd0, 17'd0, '{16'd0, 1'b1, 18'd131070, 1'b0}},
		'{ROW_STOP, 2'd0, 17'd0, '{16'd0, 1'b0, 18'd131070, 1'b1}},
		'{ROW_SEND_TYPED, ACT_START, 17'd0, '0},
		'{ROW_SEND, ACT_NOP, 17'h0A5A5, '0},
		'{ROW_SEND, ACT_START, 17'd0, '0},
		'{ROW_CFG, CFG_SPARE, 17'h1FFFF, '0},
		'{ROW_CFG, CFG_SWEEP_UP, 17'd0, '0},
		'{ROW_CFG, CFG_HEAD_START, 17'h0FFFF, '0},
		'{ROW_CFG, CFG_DISK_CYLINDERS, 17'd0, '0},	// taken as a one-cylinder disk
		'{ROW_SEND, ACT_CLEAR, 17'h0FFFF, '0},
		'{ROW_SEND, ACT_LOAD, 17'd1234, '0},
		'{ROW_SEND, ACT_LOAD, 17'd0, '0},
		'{ROW_SEND, ACT_START, 17'd0, '0},
		'{ROW_CFG, CFG_DISK_CYLINDERS, 17'h1FFFF, '0},	// above the cap
		'{ROW_CFG, CFG_HEAD_START, 17'd30000, '0},
		'{ROW_CFG, CFG_SWEEP_UP, 17'd1, '0},
		'{ROW_SEND, ACT_CLEAR, 17'd0, '0},
		'{ROW_SEND, ACT_LOAD, 17'd40000, '0},
		'{ROW_SEND, ACT_LOAD, 17'd100, '0},
		'{ROW_SEND, ACT_LOAD, 17'd30000, '0},	// equal to head: not above it
		'{ROW_SEND, ACT_LOAD, 17'd65535, '0},
		'{ROW_SEND, ACT_START, 17'd0, '0},
		'{ROW_CFG, CFG_SWEEP_UP, 17'd0, '0},
		'{ROW_SEND, ACT_LOAD, 17'd5, '0},	// appended behind the sorted store
		'{ROW_SEND, ACT_START, 17'h0FFFF, '0}
	};

	function automatic logic [CYL_W-1:0] disk_last();
		int unsigned d;
		d = mirror_disk;
		if (d == 0) d = 1;
		if (d > 32'h10000) d = 32'h10000;
		return CYL_W'(d - 1);
	endfunction

	function automatic void push_stop(logic [CYL_W-1:0] cyl, logic at_end);
		int unsigned c, h, s;
		stop_t st;
		c = cyl;
		h = head_pos;
		s = move_sum + ((c > h) ? c - h : h - c);
		if (s > MOVE_MAX) s = MOVE_MAX;
		move_sum = SUM_W'(s);
		head_pos = POS_W'(cyl);
		st.served_cylinder = cyl;
		st.is_disk_end     = at_end;
		st.total_movement  = move_sum;
		st.last_of_run     = 1'b0;
		fresh_stops.push_back(st);
	endfunction

	// advances the predictor by one command item; stops land in fresh_stops
	function automatic void plan_service_order(logic [ACT_W-1:0] act, logic [CYL_W-1:0] cyl);
		int unsigned n, first, i, j;
		logic [CYL_W-1:0] last, v;
		stop_t st;
		fresh_stops.delete();
		last = disk_last();
		case (act)
			ACT_LOAD: begin
				if (req_count < NREQ) begin
					req_store[req_count] = (cyl > last) ? last : cyl;
					req_count++;
				end
			end
			ACT_CLEAR: req_count = 0;
			ACT_START: begin
				n = req_count;
				// disk may have shrunk since the load
				for (i = 0; i < n; i++)
					if (req_store[i] > last) req_store[i] = last;
				for (i = 1; i < n; i++) begin
					v = req_store[i];
					j = i;
					while (j > 0 && req_store[j-1] > v) begin
						req_store[j] = req_store[j-1];
						j--;
					end
					req_store[j] = v;
				end
				head_pos = (mirror_head > last) ? last : mirror_head;
				move_sum = '0;
				first = n;
				for (i = n; i > 0; i--)
					if (req_store[i-1] > head_pos) first = i - 1;
				if (mirror_up) begin
					for (i = first; i < n; i++) push_stop(req_store[i], 1'b0);
					push_stop(last, 1'b1);
					push_stop('0, 1'b1);
					for (i = 0; i < first; i++) push_stop(req_store[i], 1'b0);
				end else begin
					for (i = first; i > 0; i--) push_stop(req_store[i-1], 1'b0);
					push_stop('0, 1'b1);
					push_stop(last, 1'b1);
					for (i = n; i > first; i--) push_stop(req_store[i-1], 1'b0);
				end
				st = fresh_stops.pop_back();
				st.last_of_run = 1'b1;
				fresh_stops.push_back(st);
			end
			default: ;
		endcase
	endfunction

	task automatic log_error(input string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endtask

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [CYL_W-1:0] cyl,
			input bit typed);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
		end
		@(negedge clk);
		cmd.valid    <= 1'b1;
		cmd.action   <= act;
		cmd.cylinder <= cyl;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		plan_service_order(act, cyl);
		if (!typed)
			foreach (fresh_stops[i]) pending_stops.push_back(fresh_stops[i]);
		if (act != ACT_NOP) items_sent++;
	endtask

	// block is idle once every stop is in and a load has had time to settle
	task automatic wait_idle();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending_stops.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DISK_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_HEAD_START:     mirror_head = data[CYL_W-1:0];
			CFG_DISK_CYLINDERS: mirror_disk = data;
			CFG_SWEEP_UP:       mirror_up = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CYL_W-1:0] pick_cylinder();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return mirror_head;
			3, 4:    return CYL_W'($urandom);
			default: return CYL_W'($urandom_range(0, disk_last()));
		endcase
	endfunction

	task automatic shuffle_registers();
		logic [DISK_W-1:0] disk;
		logic [CYL_W-1:0]  head;
		wait_idle();
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 7))
				0:       disk = '0;
				1:       disk = 17'd1;
				2:       disk = DISK_CYL_RESET;
				3:       disk = '1;
				4:       disk = 17'h10001;
				5:       disk = DISK_W'($urandom_range(2, 64));
				default: disk = DISK_W'($urandom);
			endcase
			cfg_write(CFG_DISK_CYLINDERS, disk);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0:       head = '0;
				1:       head = '1;
				2:       head = CYL_W'($urandom_range(0, disk_last()));
				default: head = CYL_W'($urandom);
			endcase
			cfg_write(CFG_HEAD_START, DISK_W'(head));
		end
		if ($urandom_range(0, 1) != 0)
			cfg_write(CFG_SWEEP_UP, DISK_W'($urandom_range(0, 1)));
	endtask

	// mostly clear/load/start runs; some appends to the last store, some noise
	task automatic run_batch();
		int unsigned pick, k;
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			if (pick < 70) send_item(ACT_CLEAR, CYL_W'($urandom), 1'b0);
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NREQ + 3) : $urandom_range(0, 8);
			repeat (k) send_item(ACT_LOAD, pick_cylinder(), 1'b0);
			send_item(ACT_START, CYL_W'($urandom), 1'b0);
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(ACT_W'($urandom_range(0, 3)), pick_cylinder(), 1'b0);
		end
	endtask

	// stop receiver
	initial begin
		stop.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				stop.ready <= 1'b0;
			end else begin
				stop.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	// stop checker
	initial begin
		stop_t got, want;
		forever begin
			@(posedge clk);
			if (stop.valid === 1'b1 && stop.ready === 1'b1) begin
				got = {stop.served_cylinder, stop.is_disk_end, stop.total_movement,
					stop.last_of_run};
				if (pending_stops.size() == 0) begin
					log_error($sformatf("unexpected stop: cyl %0d end %0b move %0d last %0b",
						got.served_cylinder, got.is_disk_end, got.total_movement,
						got.last_of_run));
				end else begin
					want = pending_stops.pop_front();
					if (got.served_cylinder !== want.served_cylinder ||
							got.is_disk_end !== want.is_disk_end ||
							got.total_movement !== want.total_movement ||
							got.last_of_run !== want.last_of_run)
						log_error($sformatf({"stop mismatch: expected cyl %0d end %0b move %0d",
							" last %0b, got cyl %0d end %0b move %0d last %0b"},
							want.served_cylinder, want.is_disk_end, want.total_movement,
							want.last_of_run, got.served_cylinder, got.is_disk_end,
							got.total_movement, got.last_of_run));
				end
			end
		end
	end

	// watchdog: cycles with no item accepted on either side
	initial begin
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
					(stop.valid === 1'b1 && stop.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_cscan_disk_scheduler: errors");
		$finish;
	end

	initial begin
		row_t        row;
		int unsigned goal;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_data     = '0;
		cmd.valid    = 1'b0;
		cmd.action   = ACT_LOAD;
		cmd.cylinder = '0;
		mirror_head  = '0;
		mirror_disk  = DISK_CYL_RESET;
		mirror_up    = 1'b1;
		req_count    = 0;
		head_pos     = '0;
		move_sum     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			case (row.kind)
				ROW_CFG: begin
					wait_idle();
					cfg_write(row.code, row.value);
				end
				ROW_STOP: pending_stops.push_back(row.stop);
				default:  send_item(row.code, row.value[CYL_W-1:0], row.kind == ROW_SEND_TYPED);
			endcase
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
			recv_gap_pct = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
			if (phase == 2) begin
				// long receiver hold while loads and a start keep coming
				wait_idle();
				hold_req = 1'b1;
				send_item(ACT_CLEAR, '0, 1'b0);
				repeat (6) send_item(ACT_LOAD, pick_cylinder(), 1'b0);
				send_item(ACT_START, '0, 1'b0);
			end
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(0, 3) == 0) shuffle_registers();
				run_batch();
			end
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending_stops.size() == 0)
			$display("tb_cscan_disk_scheduler: clean");
		else
			$display("tb_cscan_disk_scheduler: errors");
		$finish;
	end

endmodule
